[rtl/assert_macros.svh]
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ltq_pkg.sv]
package ltq_pkg;

  localparam int UNIT_W         = 8;
  localparam int UNIT_COUNT_DEF = 256;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic load;  // capture item, read link of current head
    logic exec;  // apply the operation, load result registers
  } cmd_t;

endpackage

[rtl/linked_transmit_queue_top.sv]
// Linked transmit queue: FIFO of unit numbers kept as a linked list.
// Result: registered in the EXEC state, shown in DONE and held there while rsp_stall is high.
// One item at a time: a new item is taken only once the last result is taken;
//   each item passes the registered link read, the update (EXEC) and the result stage (DONE).
// Reset (rst, synchronous): queue empty, all links read as identity.
`include "assert_macros.svh"

module linked_transmit_queue_top #(
  parameter int UNIT_COUNT = ltq_pkg::UNIT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       action,
  input  logic [ltq_pkg::UNIT_W-1:0] unit,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [ltq_pkg::UNIT_W-1:0] prior_tail,
  output logic                       had_tail,
  output logic [ltq_pkg::UNIT_W-1:0] head_unit,
  output logic                       not_empty,
  output logic                       pop_error
);
  import ltq_pkg::*;

  cmd_t cmd;

  ltq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  ltq_dp #(
    .UNIT_COUNT (UNIT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action     (action),
    .unit       (unit),
    .prior_tail (prior_tail),
    .had_tail   (had_tail),
    .head_unit  (head_unit),
    .not_empty  (not_empty),
    .pop_error  (pop_error)
  );

  `AST_SAME(a_perr_empty, rsp_valid && pop_error, !not_empty && !had_tail)
  `AST_SAME(a_empty_head, rsp_valid && !not_empty, head_unit == '0)
  `AST_SAME(a_push_keeps, rsp_valid && had_tail, not_empty && !pop_error)
  `AST_NEXT(a_one_item, req_valid && !req_stall, req_stall && !rsp_valid)

endmodule

[rtl/ltq_ctrl.sv]
module ltq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ltq_pkg::cmd_t cmd
);
  import ltq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DONE: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign cmd.load  = (state == S_IDLE) && req_valid;
  assign cmd.exec  = (state == S_EXEC);

endmodule

[rtl/ltq_dp.sv]
module ltq_dp #(
  parameter int UNIT_COUNT = ltq_pkg::UNIT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ltq_pkg::cmd_t              cmd,
  input  logic                       action,
  input  logic [ltq_pkg::UNIT_W-1:0] unit,
  output logic [ltq_pkg::UNIT_W-1:0] prior_tail,
  output logic                       had_tail,
  output logic [ltq_pkg::UNIT_W-1:0] head_unit,
  output logic                       not_empty,
  output logic                       pop_error
);
  import ltq_pkg::*;

  localparam int IDX_W = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

  // Link memory; an entry without its valid bit reads as its own index.
  logic [UNIT_W-1:0]     mem [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] lvalid;

  logic [UNIT_W-1:0] head, tail;
  logic              filled;

  logic              act_q;
  logic [UNIT_W-1:0] unit_q;
  logic [UNIT_W-1:0] link_q;
  logic              link_ok_q;

  logic [IDX_W-1:0]  head_idx, tail_idx;
  logic [UNIT_W-1:0] nxt;
  logic              in_range;

  logic [UNIT_W-1:0] head_next, tail_next;
  logic              filled_next;
  logic              mem_we, set_valid, clr_valid;
  logic [UNIT_W-1:0] prior_next;
  logic              had_next, perr_next;

  assign head_idx = head[IDX_W-1:0];
  assign tail_idx = tail[IDX_W-1:0];
  assign nxt      = link_ok_q ? link_q : head;
  assign in_range = ({1'b0, unit_q} < (UNIT_W+1)'(UNIT_COUNT));

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    filled_next = filled;
    mem_we      = 1'b0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    prior_next  = '0;
    had_next    = 1'b0;
    perr_next   = 1'b0;
    if (act_q == ACT_PUSH) begin
      if (filled) begin
        prior_next = tail;
        had_next   = 1'b1;
      end
      if (in_range) begin
        tail_next = unit_q;
        if (filled) begin
          mem_we    = 1'b1;
          set_valid = 1'b1;
        end else begin
          head_next   = unit_q;
          filled_next = 1'b1;
        end
      end
    end else begin
      if (!filled) begin
        perr_next = 1'b1;
      end else if (nxt == head) begin
        // last entry leaves
        head_next   = '0;
        tail_next   = '0;
        filled_next = 1'b0;
      end else begin
        head_next = nxt;
        clr_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) link_q <= mem[head_idx];
    if (cmd.exec && mem_we) mem[tail_idx] <= unit_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
      head   <= '0;
      tail   <= '0;
      filled <= 1'b0;
    end else if (cmd.exec) begin
      if (set_valid) lvalid[tail_idx] <= 1'b1;
      if (clr_valid) lvalid[head_idx] <= 1'b0;
      head   <= head_next;
      tail   <= tail_next;
      filled <= filled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q     <= action;
      unit_q    <= unit;
      link_ok_q <= lvalid[head_idx];
    end
    if (cmd.exec) begin
      prior_tail <= prior_next;
      had_tail   <= had_next;
      head_unit  <= filled_next ? head_next : '0;
      not_empty  <= filled_next;
      pop_error  <= perr_next;
    end
  end

endmodule
